[hdl/oaht_pkg.sv]
// shared types and codes for the open-addressing host table
// no dependencies
`default_nettype none

package oaht_pkg;

  localparam int KeyW  = 32;
  localparam int SlotW = 8;
  localparam int StrW  = 8;

  localparam logic KIND_ENTER  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef struct packed {
    logic            kind;
    logic [KeyW-1:0] host_key;
  } req_t;

endpackage

`default_nettype wire

[hdl/oaht_req_if.sv]
// request channel: valid/ready with kind and host key
// depends on oaht_pkg
`default_nettype none

interface oaht_req_if;
  import oaht_pkg::*;

  logic            valid;
  logic            ready;
  logic            kind;
  logic [KeyW-1:0] host_key;

  modport source (output valid, output kind, output host_key, input ready);
  modport sink   (input valid, input kind, input host_key, output ready);
endinterface

`default_nettype wire

[hdl/oaht_rsp_if.sv]
// response channel: valid/ready with hit, slot, inserted and full flags
// depends on oaht_pkg
`default_nettype none

interface oaht_rsp_if;
  import oaht_pkg::*;

  logic             valid;
  logic             ready;
  logic             hit;
  logic [SlotW-1:0] slot;
  logic             inserted;
  logic             table_full;

  modport source (output valid, output hit, output slot, output inserted,
                  output table_full, input ready);
  modport sink   (input valid, input hit, input slot, input inserted,
                  input table_full, output ready);
endinterface

`default_nettype wire

[hdl/oaht_cfg_if.sv]
// configuration write channel carrying the probe stride
// depends on oaht_pkg
`default_nettype none

interface oaht_cfg_if;
  import oaht_pkg::*;

  logic            valid;
  logic            ready;
  logic [StrW-1:0] probe_stride;

  modport source (output valid, output probe_stride, input ready);
  modport sink   (input valid, input probe_stride, output ready);
endinterface

`default_nettype wire

[hdl/open_addressing_host_table.sv]
// top level of the open-addressing host table: front queue and probe back end
// depends on oaht_pkg, the three channel interfaces, oaht_front and oaht_back
`default_nettype none

// Open-addressed table of 32-bit host keys with linear probing. The home slot
// is the key's low byte modulo TABLE_SLOTS; each collision steps by the
// configured probe stride. A request first leaves the queue; each probed
// slot is then a memory read followed by a compare, and a finished probe
// waits in the compare step until the response register is free.
// Requests queue two deep in front of the prober while a response waits.
// After reset a clearing pass over every slot empties the table, and
// no request is accepted until it ends. The stride register accepts writes
// at any time and must only be written while no request is in flight.
module open_addressing_host_table #(
  parameter int TABLE_SLOTS = 256
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  oaht_req_if.sink   req_i,
  oaht_rsp_if.source rsp_o,
  oaht_cfg_if.sink   cfg_i
);
  import oaht_pkg::*;

  localparam int IW = $clog2(TABLE_SLOTS);

  function automatic logic [256*IW-1:0] build_mod_lut();
    logic [256*IW-1:0] lut;
    lut = '0;
    for (int i = 0; i < 256; i++) begin
      lut[i*IW +: IW] = IW'(i % TABLE_SLOTS);
    end
    return lut;
  endfunction

  localparam logic [256*IW-1:0] MOD_LUT = build_mod_lut();

  req_t          q_req;
  logic [IW-1:0] q_home;
  logic          q_valid;
  logic          q_pop;
  logic          clr_busy;

  oaht_front #(
    .IW      (IW),
    .MOD_LUT (MOD_LUT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_i),
    .clr_busy_i (clr_busy),
    .q_req_o    (q_req),
    .q_home_o   (q_home),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop)
  );

  oaht_back #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .IW          (IW),
    .MOD_LUT     (MOD_LUT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_i),
    .rsp_o      (rsp_o),
    .q_req_i    (q_req),
    .q_home_i   (q_home),
    .q_valid_i  (q_valid),
    .q_pop_o    (q_pop),
    .clr_busy_o (clr_busy)
  );

endmodule

`default_nettype wire

[hdl/oaht_front.sv]
// front end: accepts requests, computes the home slot, queues them (two entries)
// depends on oaht_pkg and oaht_req_if
`default_nettype none

module oaht_front #(
  parameter int                       IW      = 8,
  parameter logic [256*IW-1:0]        MOD_LUT = '0
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  oaht_req_if.sink           req_i,
  input  wire logic          clr_busy_i,
  output oaht_pkg::req_t     q_req_o,
  output logic [IW-1:0]      q_home_o,
  output logic               q_valid_o,
  input  wire logic          q_pop_i
);
  import oaht_pkg::*;

  req_t          ent_req_q  [2];
  logic [IW-1:0] ent_home_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q, cnt_d;
  logic          push;
  logic          pop;
  logic [IW-1:0] home;

  assign home        = MOD_LUT[int'(req_i.host_key[7:0])*IW +: IW];
  assign req_i.ready = (cnt_q != 2'd2) && !clr_busy_i;
  assign push        = req_i.valid && req_i.ready;
  assign pop         = q_pop_i && (cnt_q != 2'd0);

  assign q_valid_o = (cnt_q != 2'd0);
  assign q_req_o   = ent_req_q[rd_ptr_q];
  assign q_home_o  = ent_home_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) cnt_d = cnt_q + 2'd1;
    else if (!push && pop) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop) rd_ptr_q <= !rd_ptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_req_q[wr_ptr_q]  <= '{kind: req_i.kind, host_key: req_i.host_key};
      ent_home_q[wr_ptr_q] <= home;
    end
  end

endmodule

`default_nettype wire

[hdl/oaht_back.sv]
// back end: clearing pass, probe sequencer over the slot memory, response register
// depends on oaht_pkg, oaht_rsp_if and oaht_cfg_if
`default_nettype none

module oaht_back #(
  parameter int                TABLE_SLOTS = 256,
  parameter int                IW          = 8,
  parameter logic [256*IW-1:0] MOD_LUT     = '0
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  oaht_cfg_if.sink           cfg_i,
  oaht_rsp_if.source         rsp_o,
  input  oaht_pkg::req_t     q_req_i,
  input  wire logic [IW-1:0] q_home_i,
  input  wire logic          q_valid_i,
  output logic               q_pop_o,
  output logic               clr_busy_o
);
  import oaht_pkg::*;

  localparam int SW = (IW > SlotW) ? IW : SlotW;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_CHECK = 2'd3;

  logic [KeyW:0]   mem_q [TABLE_SLOTS];
  logic [KeyW:0]   rd_q;

  logic [1:0]      state_q, state_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic [IW-1:0]   home_q;
  logic [KeyW-1:0] key_q;
  logic            kind_q;
  logic [IW-1:0]   clr_cnt_q;
  logic [IW-1:0]   stride_q;

  logic            rsp_valid_q, rsp_valid_d;
  logic            hit_q, hit_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic            ins_q, ins_d;
  logic            full_q, full_d;

  logic [IW:0]     sum;
  logic [IW:0]     nxt;
  logic [IW-1:0]   nxt_idx;
  logic [SW-1:0]   idx_wide;
  logic            rd_vld, match, wrap, out_free;
  logic            wr_en;
  logic [IW-1:0]   wr_addr;
  logic [KeyW:0]   wr_data;

  assign cfg_i.ready = 1'b1;
  assign clr_busy_o  = (state_q == ST_CLEAR);
  assign q_pop_o     = (state_q == ST_IDLE) && q_valid_i;

  assign sum      = {1'b0, idx_q} + {1'b0, stride_q};
  assign nxt      = (sum >= (IW+1)'(TABLE_SLOTS)) ? sum - (IW+1)'(TABLE_SLOTS) : sum;
  assign nxt_idx  = nxt[IW-1:0];
  assign idx_wide = SW'(idx_q);
  assign rd_vld   = rd_q[KeyW];
  assign match    = rd_vld && (rd_q[KeyW-1:0] == key_q);
  assign wrap     = rd_vld && !match && (nxt_idx == home_q);
  assign out_free = !rsp_valid_q || rsp_o.ready;

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.hit        = hit_q;
  assign rsp_o.slot       = slot_q;
  assign rsp_o.inserted   = ins_q;
  assign rsp_o.table_full = full_q;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    rsp_valid_d = rsp_valid_q && !rsp_o.ready;
    hit_d       = hit_q;
    slot_d      = slot_q;
    ins_d       = ins_q;
    full_d      = full_q;
    wr_en       = 1'b0;
    wr_addr     = idx_q;
    wr_data     = {1'b1, key_q};
    case (state_q)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_q;
        wr_data = '0;
        if (clr_cnt_q == IW'(TABLE_SLOTS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          idx_d   = q_home_i;
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (!rd_vld || match || wrap) begin
          if (out_free) begin
            rsp_valid_d = 1'b1;
            hit_d       = match;
            full_d      = wrap;
            slot_d      = wrap ? '0 : idx_wide[SlotW-1:0];
            ins_d       = !rd_vld && (kind_q == KIND_ENTER);
            wr_en       = !rd_vld && (kind_q == KIND_ENTER);
            state_d     = ST_IDLE;
          end
        end else begin
          idx_d   = nxt_idx;
          state_d = ST_READ;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      rsp_valid_q <= 1'b0;
      stride_q    <= MOD_LUT[1*IW +: IW];
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
      if (state_q == ST_CLEAR) clr_cnt_q <= clr_cnt_q + IW'(1);
      if (cfg_i.valid) stride_q <= MOD_LUT[int'(cfg_i.probe_stride)*IW +: IW];
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q  <= idx_d;
    hit_q  <= hit_d;
    slot_q <= slot_d;
    ins_q  <= ins_d;
    full_q <= full_d;
    if (q_pop_o) begin
      home_q <= q_home_i;
      key_q  <= q_req_i.host_key;
      kind_q <= q_req_i.kind;
    end
  end

  // slot memory: {valid, key}, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (state_q == ST_READ) rd_q <= mem_q[idx_q];
  end

endmodule

`default_nettype wire
